### rtl/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, constants and the Gray-code direction table for the
// quadrature detent decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

    // Width of the signed step accumulator and of its widened sum.
    localparam int ACC_W = 9;
    localparam int SUM_W = ACC_W + 1;

    // Width of the steps-per-detent setting.
    localparam int PER_W = 8;

    // Stream word widths, padded to whole bytes.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // Configuration port widths.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes.
    localparam logic REG_STEPS_PER_DETENT = 1'b0;

    // Reset value of the steps-per-detent register.
    localparam logic [PER_W-1:0] STEPS_PER_DETENT_RST = PER_W'(4);

    typedef logic signed [1:0]       step_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [1:0]              phase_t;
    typedef logic [PER_W-1:0]        per_t;

    // Decoder state carried from one sample to the next.
    typedef struct packed {
        logic   seeded;
        phase_t last_phase;
        acc_t   acc;
    } qdd_state_t;

    localparam step_t STEP_NONE = 2'sb00;
    localparam step_t STEP_FWD  = 2'sb01;
    localparam step_t STEP_REV  = 2'sb11;

    // Direction of a move, indexed by {previous phase, current phase}.
    // No change and a change of both phases at once both give no step.
    function automatic step_t quad_dir(input logic [3:0] code);
        step_t dir;
        unique case (code)
            4'd1, 4'd7, 4'd8, 4'd14: dir = STEP_REV;
            4'd2, 4'd4, 4'd11, 4'd13: dir = STEP_FWD;
            default:                  dir = STEP_NONE;
        endcase
        return dir;
    endfunction

endpackage

### rtl/qdd_cfg.sv
// ----------------------------------------------------------------------------
// qdd_cfg
// Register file behind the configuration port: holds the steps-per-detent
// setting and returns it on reads.
// ----------------------------------------------------------------------------
module qdd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qdd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qdd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qdd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output qdd_pkg::per_t                  steps_per_detent
);
    import qdd_pkg::*;

    per_t steps_per_detent_reg;
    logic reg_index;
    logic wr_en;

    // Registers lie on 32-bit word boundaries.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    // Setting register; writes to unmapped addresses are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_detent_reg <= STEPS_PER_DETENT_RST;
        end
        else if (wr_en && (reg_index == REG_STEPS_PER_DETENT))
        begin
            steps_per_detent_reg <= pwdata[PER_W-1:0];
        end
    end

    // Read-back path.
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_STEPS_PER_DETENT)
        begin
            prdata = APB_DATA_W'(steps_per_detent_reg);
        end
    end

    assign steps_per_detent = steps_per_detent_reg;

endmodule

### rtl/qdd_step.sv
// ----------------------------------------------------------------------------
// qdd_step
// Decodes one phase sample against the previous one, accumulates valid
// steps and works out the detent report and the next decoder state.
// ----------------------------------------------------------------------------
module qdd_step (
    input  qdd_pkg::phase_t     phase,
    input  qdd_pkg::per_t       per,
    input  qdd_pkg::qdd_state_t state_cur,
    output qdd_pkg::qdd_state_t state_next,
    output qdd_pkg::step_t      detent_step
);
    import qdd_pkg::*;

    step_t dir;
    sum_t  sum;
    sum_t  per_pos;
    sum_t  per_neg;
    logic  per_direct;

    // Direction of this move; the first sample only seeds the phase.
    assign dir = state_cur.seeded ? quad_dir({state_cur.last_phase, phase}) : STEP_NONE;

    assign sum        = SUM_W'(state_cur.acc) + SUM_W'(dir);
    assign per_pos    = sum_t'({1'b0, 1'b0, per});
    assign per_neg    = -per_pos;
    assign per_direct = (per <= PER_W'(1));

    // Accumulate and group steps into detents.
    always_comb
    begin
        state_next.seeded     = 1'b1;
        state_next.last_phase = phase;
        state_next.acc        = state_cur.acc;
        detent_step           = STEP_NONE;
        if (dir != STEP_NONE)
        begin
            priority if (per_direct)
            begin
                state_next.acc = '0;
                detent_step    = dir;
            end
            else if (sum >= per_pos)
            begin
                state_next.acc = ACC_W'(sum - per_pos);
                detent_step    = STEP_FWD;
            end
            else if (sum <= per_neg)
            begin
                state_next.acc = ACC_W'(sum + per_pos);
                detent_step    = STEP_REV;
            end
            else
            begin
                state_next.acc = ACC_W'(sum);
            end
        end
    end

endmodule

### rtl/qdd_core.sv
// ----------------------------------------------------------------------------
// qdd_core
// Input register, decoder state and result register around the step logic.
// Takes one sample per cycle while the result side keeps moving.
// ----------------------------------------------------------------------------
module qdd_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [qdd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  qdd_pkg::per_t                  steps_per_detent
);
    import qdd_pkg::*;

    logic       in_valid_reg;
    phase_t     phase_reg;
    qdd_state_t state_reg;
    qdd_state_t state_next;
    logic       out_valid_reg;
    step_t      out_step_reg;
    step_t      step_next;
    logic       advance;
    logic       fire;
    logic       take;

    // Handshake: the input register drains whenever the result register can load.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Input register; the phase code is {A, B}.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            phase_reg <= {s_axis_tdata[0], s_axis_tdata[1]};
        end
    end

    qdd_step u_step (
        .phase       (phase_reg),
        .per         (steps_per_detent),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .detent_step (step_next)
    );

    // Decoder state advances once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_step_reg <= step_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({6'b0, out_step_reg});

    // A sample held back by a stalled result stays in the input register.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word lost while result stalled");

    // The seeding sample never reports a detent.
    a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !state_reg.seeded) |=> (out_step_reg == STEP_NONE))
        else $error("seeding sample reported a detent");

    // In direct mode the accumulator is emptied after every valid step.
    a_direct_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (step_next != STEP_NONE) && (steps_per_detent <= PER_W'(1)))
        |=> (state_reg.acc == '0))
        else $error("accumulator not cleared in direct mode");

    // The accumulator magnitude stays within the setting range.
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.acc != acc_t'({1'b1, {(ACC_W-1){1'b0}}}))
        else $error("accumulator out of range");

endmodule

### rtl/quadrature_detent_decoder.sv
// Path: a sample accepted into the input register moves into the result register once that
// register can load, and its word is then offered on the detent stream.
// Throughput: one sample per cycle, set by the single decode step between the input
// register and the result register; while a result word stalls, one more sample waits.
// Reset: rst_n clears the handshake state, the decoder state and the
// accumulator; steps_per_detent returns to 4 and the first sample seeds.
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// X4 quadrature decoder that groups valid steps into detent counts, with a
// configuration port for the steps-per-detent setting.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qdd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qdd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qdd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Sample stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [0] phase_a, [1] phase_b
    // Detent stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [qdd_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [1:0] detent_step
);
    import qdd_pkg::*;

    per_t steps_per_detent;

    qdd_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .steps_per_detent (steps_per_detent)
    );

    qdd_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .steps_per_detent (steps_per_detent)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Quadrature detent decoder testbench
// Drives encoder phase samples into the decoder and checks every detent word
// against a cycle-free model of the Gray-code decode and detent grouping.
// Walks through several steps-per-detent settings over the APB port.
// Random stall bursts are applied on both streams.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qdd_pkg::*;

    // Byte addresses of the steps-per-detent register and of an unused slot.
    localparam logic [APB_ADDR_W-1:0] ADDR_STEPS = APB_ADDR_W'(4 * REG_STEPS_PER_DETENT);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = ADDR_STEPS + APB_ADDR_W'(4);

    // Cycles left after the last detent word before the block is idle.
    localparam int SETTLE_CYCLES = 4;

    // Detent model and queue of detent words still to arrive.
    class detent_scoreboard;
        per_t   detent_period;
        phase_t prev_phase;
        logic   seeded;
        acc_t   step_sum;
        step_t  expected_steps[$];
        int     errors;

        function new();
            detent_period = STEPS_PER_DETENT_RST;
            prev_phase    = '0;
            seeded        = 1'b0;
            step_sum      = '0;
            errors        = 0;
        endfunction

        function void set_period(per_t value);
            detent_period = value;
        endfunction

        // Position of a phase code along the forward Gray sequence 0, 2, 3, 1.
        function int gray_pos(phase_t ph);
            case (ph)
                2'd0:    return 0;
                2'd2:    return 1;
                2'd3:    return 2;
                default: return 3;
            endcase
        endfunction

        // Work out the detent word that one accepted sample will produce.
        function void note_sample(phase_t ph);
            int    move;
            int    sum;
            int    limit;
            step_t result;
            result = STEP_NONE;
            if (!seeded) begin
                seeded = 1'b1;
            end
            else begin
                move = (gray_pos(ph) - gray_pos(prev_phase) + 4) % 4;
                // A quarter turn either way is a step; no change or a jump of
                // two positions leaves everything as it was.
                if (move == 1 || move == 3) begin
                    sum   = int'(step_sum) + ((move == 1) ? 1 : -1);
                    limit = int'(detent_period);
                    if (limit <= 1) begin
                        sum    = 0;
                        result = (move == 1) ? STEP_FWD : STEP_REV;
                    end
                    else if (sum >= limit) begin
                        sum    = sum - limit;
                        result = STEP_FWD;
                    end
                    else if (sum <= -limit) begin
                        sum    = sum + limit;
                        result = STEP_REV;
                    end
                    step_sum = acc_t'(sum);
                end
            end
            prev_phase = ph;
            expected_steps.push_back(result);
        endfunction

        function void check_detent(step_t got);
            step_t want;
            if (expected_steps.size() == 0) begin
                $error("detent_step: word with none expected, actual %0d", got);
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            if (got !== want) begin
                $error("detent_step: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_steps.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [0] phase_a, [1] phase_b
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [1:0] detent_step

    detent_scoreboard sb;
    phase_t           cur_phase;
    bit               idle_on;
    int               stall_left;

    quadrature_detent_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: ready with random stall bursts while idling is enabled.
    always @(negedge clk)
    begin
        if (idle_on && stall_left > 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 8) begin
            stall_left    = $urandom_range(1, 19) - 1;
            m_axis_tready = 1'b0;
        end
        else begin
            m_axis_tready = 1'b1;
        end
    end

    // Check each accepted detent word.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_detent(step_t'(m_axis_tdata[1:0]));
    end

    // Next phase code one step along the Gray sequence.
    function automatic phase_t gray_next(phase_t ph, bit fwd);
        case (ph)
            2'd0:    return fwd ? 2'd2 : 2'd1;
            2'd2:    return fwd ? 2'd3 : 2'd0;
            2'd3:    return fwd ? 2'd1 : 2'd2;
            default: return fwd ? 2'd0 : 2'd3;
        endcase
    endfunction

    // Offer one sample word, with an occasional gap in front of it.
    task automatic send_sample(input phase_t ph);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 8)
            gap = $urandom_range(1, 19);
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_DATA_W'({ph[0], ph[1]});
        do @(posedge clk); while (!s_axis_tready);
        cur_phase = ph;
        sb.note_sample(ph);
    endtask

    // Stop sending and wait until every detent word has come back.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_STEPS)
            sb.set_period(per_t'(data));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read the steps-per-detent register back and compare with the model.
    task automatic check_period();
        logic [APB_DATA_W-1:0] want;
        want = APB_DATA_W'(sb.detent_period);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_STEPS;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) begin
            $error("steps_per_detent: expected %0d, actual %0d", want, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Runs of steps in one direction, salted with repeats, jumps and noise.
    task automatic wander(input int count, input int max_run, input int noise_pct);
        int     sent;
        int     run_len;
        bit     fwd;
        phase_t nxt;
        sent = 0;
        while (sent < count) begin
            fwd     = $urandom_range(0, 1);
            run_len = $urandom_range(1, max_run);
            for (int k = 0; k < run_len && sent < count; k++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    case ($urandom_range(0, 2))
                        0:       nxt = cur_phase;
                        1:       nxt = cur_phase ^ 2'b11;
                        default: nxt = phase_t'($urandom_range(0, 3));
                    endcase
                end
                else begin
                    nxt = gray_next(cur_phase, fwd);
                end
                send_sample(nxt);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        per_t periods[8];
        int   counts[8];
        int   runs[8];

        sb            = new();
        cur_phase     = '0;
        idle_on       = 1'b0;
        stall_left    = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Reset setting of four steps: seed, a forward detent, a repeated
        // sample, a jump of both phases and a reverse detent.
        check_period();
        send_sample(2'd3);
        send_sample(2'd1);
        send_sample(2'd0);
        send_sample(2'd2);
        send_sample(2'd3);
        send_sample(2'd3);
        send_sample(2'd0);
        send_sample(2'd1);
        send_sample(2'd3);
        send_sample(2'd2);
        send_sample(2'd0);
        drain();

        // Setting of zero, written with junk in the upper data bits.
        apb_write(ADDR_STEPS, 32'hA5A5_5A00);
        check_period();
        send_sample(2'd2);
        send_sample(2'd1);
        send_sample(2'd0);
        send_sample(2'd1);
        drain();

        // Setting of one, then a write to an unused slot that must not land.
        apb_write(ADDR_STEPS, 32'h0000_0001);
        send_sample(2'd3);
        send_sample(2'd2);
        send_sample(2'd0);
        send_sample(2'd2);
        drain();
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        check_period();

        // Random phases over a range of settings; the accumulator is carried
        // from one setting to the next, so a large count meets a small limit.
        periods = '{8'd0, 8'd3, 8'd255, 8'd2, per_t'($urandom_range(5, 254)),
                    8'd128, 8'd1, 8'd4};
        counts  = '{120, 150, 600, 150, 150, 250, 80, 120};
        runs    = '{8, 12, 700, 10, 2 * int'(periods[4]) + 4, 400, 8, 20};
        for (int p = 0; p < 8; p++) begin
            apb_write(ADDR_STEPS, APB_DATA_W'(periods[p]));
            check_period();
            idle_on = (p < 7);
            wander(counts[p], runs[p], 10);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() > 0) begin
            $error("detent_step: %0d words never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
